/* hdl/plint_pkg.sv */
// Shared types and constants for the polar line intersection pipeline.
// No dependencies; used by plint_qsin, plint_div and polar_line_intersection.
package plint_pkg;

    // Field widths of the words
    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int RHO_BITS   = 16;
    localparam int DIM_BITS   = 15;

    // Internal datapath widths
    localparam int TRIG_BITS = 32;                       // signed Q30 sine/cosine
    localparam int NUM_BITS  = RHO_BITS + TRIG_BITS + 1; // numerator after subtract
    localparam int DEN_BITS  = 34;                       // truncated Q30 denominator
    localparam int PROD_BITS = 2 * TRIG_BITS;            // Q60 cross products

    // Pipeline depths
    localparam int TAYLOR_TERMS = 7;
    localparam int SIN_LAT      = 2 + 2 * TAYLOR_TERMS + 1;
    localparam int DIV_LAT      = COORD_BITS + 2;
    localparam int PIPE_LAT     = 1 + SIN_LAT + 2 + DIV_LAT;

    // Fixed-point constants
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 15'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 15'd480;

    typedef struct packed {
        logic signed [RHO_BITS-1:0] rho_first;
        logic [ANGLE_BITS-1:0]      theta_first;
        logic signed [RHO_BITS-1:0] rho_second;
        logic [ANGLE_BITS-1:0]      theta_second;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
        logic                         is_parallel;
        logic                         inside_image;
    } t_out_word;

    // Folded angle for one sine evaluation
    typedef struct packed {
        logic [31:0] g;
        logic        neg;
    } t_fold;

    // Reciprocal multipliers: floor(p/k) = (p*M) >> S, exact for p < 2^32.
    // Series divisors in order: 210, 156, 110, 72, 42, 20, 6.
    function automatic logic [32:0] recip_mult(input int k);
        logic [32:0] m;
        case (k)
            0:       m = 33'd5235769657;
            1:       m = 33'd7048151461;
            2:       m = 33'd4997780127;
            3:       m = 33'd7635497416;
            4:       m = 33'd6544712071;
            5:       m = 33'd6871947674;
            default: m = 33'd5726623062;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] recip_shift(input int k);
        logic [6:0] s;
        case (k)
            0, 1:    s = 7'd40;
            2, 3:    s = 7'd39;
            4:       s = 7'd38;
            5:       s = 7'd37;
            default: s = 7'd35;
        endcase
        return s;
    endfunction

endpackage

/* hdl/plint_qsin.sv */
// Pipelined quarter-wave sine in Q30 with sign applied at the end.
// Depends on plint_pkg for constants and the reciprocal tables.
module plint_qsin (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [31:0]                           i_angle,
    input  logic                                  i_neg,
    output logic signed [plint_pkg::TRIG_BITS-1:0] o_sin
);

    localparam int N = plint_pkg::TAYLOR_TERMS;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] r2;
        logic        neg;
    } t_lane;

    logic [31:0] r_r0;
    logic        r_neg0;
    t_lane       r_l1;
    t_lane       r_la [N];
    t_lane       r_lb [N];
    logic [31:0] r_p  [N];
    logic [30:0] r_q  [N];

    logic [63:0] w_rad;
    logic [63:0] w_sq;

    // angle to radians, then square
    assign w_rad = i_angle * plint_pkg::PI_Q30;
    assign w_sq  = r_r0 * r_r0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r0     <= w_rad[63:32];
            r_neg0   <= i_neg;
            r_l1.r   <= r_r0;
            r_l1.r2  <= w_sq[61:30];
            r_l1.neg <= r_neg0;
        end
    end

    // Horner steps of the series, two stages each: product, then divide
    for (genvar k = 0; k < N; k++) begin : g_term
        t_lane       w_lin;
        logic [30:0] w_u;
        logic [62:0] w_pa;
        logic [64:0] w_pb;
        logic [64:0] w_sh;

        if (k == 0) begin : g_first
            assign w_lin = r_l1;
            assign w_u   = plint_pkg::ONE_Q30;
        end else begin : g_next
            assign w_lin = r_lb[k-1];
            assign w_u   = plint_pkg::ONE_Q30 - r_q[k-1];
        end

        assign w_pa = w_lin.r2 * w_u;
        assign w_pb = r_p[k] * plint_pkg::recip_mult(k);
        assign w_sh = w_pb >> plint_pkg::recip_shift(k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_la[k] <= w_lin;
                r_p[k]  <= w_pa[61:30];
                r_lb[k] <= r_la[k];
                r_q[k]  <= w_sh[30:0];
            end
        end
    end

    // last multiply by r and sign
    logic [30:0] w_uf;
    logic [62:0] w_pf;
    logic [31:0] w_s;

    assign w_uf = plint_pkg::ONE_Q30 - r_q[N-1];
    assign w_pf = r_lb[N-1].r * w_uf;
    assign w_s  = w_pf[61:30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= r_lb[N-1].neg ? -$signed(w_s) : $signed(w_s);
        end
    end

endmodule

/* hdl/plint_div.sv */
// Pipelined restoring divider, one quotient bit a stage, truncating toward
// zero and saturating to the coordinate range. Depends on plint_pkg.
module plint_div (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [plint_pkg::NUM_BITS-1:0]  i_num,
    input  logic signed [plint_pkg::DEN_BITS-1:0]  i_den,
    output logic signed [plint_pkg::COORD_BITS-1:0] o_quo
);

    localparam int CB    = plint_pkg::COORD_BITS;
    localparam int REM_W = plint_pkg::DEN_BITS + 4 + CB;

    localparam logic [CB-1:0] Q_MAX  = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] Q_HALF = {1'b1, {(CB-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dv;
        logic [CB-1:0]    quo;
        logic             neg;
        logic             ovf;
    } t_dlane;

    t_dlane r_st [CB+1];

    logic [plint_pkg::NUM_BITS-1:0] w_an;
    logic [plint_pkg::DEN_BITS-1:0] w_ad;
    logic [REM_W-1:0]               w_dv;

    // magnitudes, divisor is 16*d, and the range check
    assign w_an = i_num[plint_pkg::NUM_BITS-1] ? 
                  plint_pkg::NUM_BITS'(-i_num) : plint_pkg::NUM_BITS'(i_num);
    assign w_ad = i_den[plint_pkg::DEN_BITS-1] ?
                  plint_pkg::DEN_BITS'(-i_den) : plint_pkg::DEN_BITS'(i_den);
    assign w_dv = REM_W'(w_ad) << 4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem <= REM_W'(w_an);
            r_st[0].dv  <= w_dv;
            r_st[0].quo <= '0;
            r_st[0].neg <= i_num[plint_pkg::NUM_BITS-1] ^ i_den[plint_pkg::DEN_BITS-1];
            r_st[0].ovf <= REM_W'(w_an) >= (w_dv << CB);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < CB; j++) begin : g_step
        localparam int SH = CB - 1 - j;
        logic [REM_W-1:0] w_trial;
        t_dlane           w_nx;

        assign w_trial = r_st[j].dv << SH;

        always_comb begin
            w_nx = r_st[j];
            if (r_st[j].rem >= w_trial) begin
                w_nx.rem     = r_st[j].rem - w_trial;
                w_nx.quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1] <= w_nx;
            end
        end
    end

    // sign and saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_st[CB].neg) begin
                o_quo <= (r_st[CB].ovf || r_st[CB].quo[CB-1]) ? Q_MAX : r_st[CB].quo;
            end else begin
                o_quo <= (r_st[CB].ovf || r_st[CB].quo > Q_HALF) ? Q_HALF : -r_st[CB].quo;
            end
        end
    end

endmodule

/* hdl/polar_line_intersection.sv */
// Top level of the polar line intersection pipeline.
// Depends on plint_pkg, plint_qsin and plint_div.
//
// Takes a pair of lines in normal form (rho in 1/16 pixel, theta as a
// fraction of pi) per word and returns their crossing point, truncated toward
// zero and saturated, with a parallel flag and an inside-image flag. One pair
// is accepted every cycle while the output register is free or being taken;
// each pair then passes through the 17-stage sine/cosine pipeline and the
// 18-stage divider that produces one quotient bit a stage. The whole pipeline
// holds while a finished result waits, so no word is lost or repeated. The
// image size registers should be written only when the pipeline is empty.
module polar_line_intersection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  plint_pkg::t_in_word                  i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output plint_pkg::t_out_word                 o_out_word,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [plint_pkg::DIM_BITS-1:0]       i_cfg_data
);

    localparam int AB  = plint_pkg::ANGLE_BITS;
    localparam int CB  = plint_pkg::COORD_BITS;
    localparam int RB  = plint_pkg::RHO_BITS;
    localparam int TB  = plint_pkg::TRIG_BITS;
    localparam int NB  = plint_pkg::NUM_BITS;
    localparam int DB  = plint_pkg::DEN_BITS;
    localparam int PB  = plint_pkg::PROD_BITS;
    localparam int LAT = plint_pkg::PIPE_LAT;
    localparam int SL  = plint_pkg::SIN_LAT;
    localparam int DL  = plint_pkg::DIV_LAT;

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic r_out_valid;
    plint_pkg::t_out_word r_out;

    logic [plint_pkg::DIM_BITS-1:0] r_img_w;
    logic [plint_pkg::DIM_BITS-1:0] r_img_h;

    // pipeline advances whenever the output register is free or being taken
    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= plint_pkg::WIDTH_RESET;
            r_img_h <= plint_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                plint_pkg::CFG_WIDTH:  r_img_w <= i_cfg_data;
                plint_pkg::CFG_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid line alongside the data
    assign n_vld = {r_vld[LAT-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= n_vld;
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // quadrant folding
    function automatic plint_pkg::t_fold fold_sin(input logic [AB-1:0] theta);
        logic [31:0] t;
        plint_pkg::t_fold f;
        t     = {theta, {(32-AB){1'b0}}};
        f.neg = 1'b0;
        f.g   = (t <= plint_pkg::HALF_TURN) ? t : 32'(33'h1_0000_0000 - {1'b0, t});
        return f;
    endfunction

    function automatic plint_pkg::t_fold fold_cos(input logic [AB-1:0] theta);
        logic [31:0] t;
        plint_pkg::t_fold f;
        t = {theta, {(32-AB){1'b0}}};
        if (t < plint_pkg::HALF_TURN) begin
            f.g   = plint_pkg::HALF_TURN - t;
            f.neg = 1'b0;
        end else begin
            f.g   = t - plint_pkg::HALF_TURN;
            f.neg = 1'b1;
        end
        return f;
    endfunction

    plint_pkg::t_fold r_fold [4];
    logic signed [RB-1:0] r_rho1 [SL+1];
    logic signed [RB-1:0] r_rho2 [SL+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fold[0] <= fold_sin(i_in_word.theta_first);
            r_fold[1] <= fold_cos(i_in_word.theta_first);
            r_fold[2] <= fold_sin(i_in_word.theta_second);
            r_fold[3] <= fold_cos(i_in_word.theta_second);
            r_rho1[0] <= i_in_word.rho_first;
            r_rho2[0] <= i_in_word.rho_second;
            for (int i = 1; i <= SL; i++) begin
                r_rho1[i] <= r_rho1[i-1];
                r_rho2[i] <= r_rho2[i-1];
            end
        end
    end

    // sine and cosine of both angles
    logic signed [TB-1:0] w_trig [4];

    for (genvar i = 0; i < 4; i++) begin : g_trig
        plint_qsin u_qsin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (r_fold[i].g),
            .i_neg   (r_fold[i].neg),
            .o_sin   (w_trig[i])
        );
    end

    // cross products
    logic signed [PB-1:0] r_s1c2, r_c1s2;
    logic signed [RB+TB-1:0] r_r2s1, r_r1s2, r_r1c2, r_r2c1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1c2 <= w_trig[0] * w_trig[3];
            r_c1s2 <= w_trig[1] * w_trig[2];
            r_r2s1 <= r_rho2[SL] * w_trig[0];
            r_r1s2 <= r_rho1[SL] * w_trig[2];
            r_r1c2 <= r_rho1[SL] * w_trig[3];
            r_r2c1 <= r_rho2[SL] * w_trig[1];
        end
    end

    // denominator truncated to Q30, numerators
    logic signed [PB-1:0] w_d60, w_dadj;
    logic signed [DB-1:0] r_d;
    logic signed [NB-1:0] r_nx, r_ny;
    logic                 r_par [DL+1];

    assign w_d60  = r_s1c2 - r_c1s2;
    assign w_dadj = w_d60[PB-1] ? w_d60 + PB'(64'h3FFF_FFFF) : w_d60;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d      <= w_dadj[PB-1:30];
            r_par[0] <= (w_dadj[PB-1:30] == '0);
            r_nx     <= NB'(r_r2s1) - NB'(r_r1s2);
            r_ny     <= NB'(r_r1c2) - NB'(r_r2c1);
            for (int i = 1; i <= DL; i++) begin
                r_par[i] <= r_par[i-1];
            end
        end
    end

    // coordinate division
    logic signed [CB-1:0] w_x, w_y;

    plint_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nx),
        .i_den (r_d),
        .o_quo (w_x)
    );

    plint_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_ny),
        .i_den (r_d),
        .o_quo (w_y)
    );

    // output register with inside-image test
    logic w_inside;

    assign w_inside = !w_x[CB-1] && !w_y[CB-1] &&
                      ($signed({w_x[CB-1], w_x}) < $signed({2'b00, r_img_w})) &&
                      ($signed({w_y[CB-1], w_y}) < $signed({2'b00, r_img_h}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.cross_x      <= r_par[DL] ? '0 : w_x;
            r_out.cross_y      <= r_par[DL] ? '0 : w_y;
            r_out.is_parallel  <= r_par[DL];
            r_out.inside_image <= !r_par[DL] && w_inside;
        end
    end

    // checks
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_vld == '0))
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("valid line moved during a stall");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.is_parallel) |->
        (o_out_word.cross_x == '0 && o_out_word.cross_y == '0 &&
         !o_out_word.inside_image))
        else $error("parallel result with non-zero fields");

    a_inside_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.inside_image) |->
        (!o_out_word.cross_x[CB-1] && !o_out_word.cross_y[CB-1]))
        else $error("inside flag on a negative coordinate");

endmodule

/* dv/tb_top.sv */
// Testbench for polar_line_intersection: streams line pairs through the
// valid/ready words and checks each crossing point against a local predictor.
// Depends on plint_pkg and the polar_line_intersection RTL.
module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM    = 830;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    plint_pkg::t_in_word  i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    plint_pkg::t_out_word o_out_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [plint_pkg::DIM_BITS-1:0] i_cfg_data;

    // predictor copy of the image size
    logic [plint_pkg::DIM_BITS-1:0] img_w;
    logic [plint_pkg::DIM_BITS-1:0] img_h;

    plint_pkg::t_out_word crossing_q[$];
    int        n_errors;
    int        n_pairs;
    int        n_results;
    int        n_parallel;
    int        n_inside;
    int        hold_off;
    bit        gaps_on;
    bit        stalls_on;
    int        quiet_cycles;

    polar_line_intersection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sine of g*pi/2^32 for g in [0, 2^31], Q30, truncating series
    function automatic longint quarter_sine(longint unsigned g);
        longint unsigned r;
        longint unsigned r2;
        longint unsigned u;
        longint unsigned div[7];
        div = '{210, 156, 110, 72, 42, 20, 6};
        r  = (g * 64'd3373259426) >> 32;
        r2 = (r * r) >> 30;
        u  = 64'd1 << 30;
        for (int k = 0; k < 7; k++)
            u = (64'd1 << 30) - ((r2 * u) >> 30) / div[k];
        return longint'((r * u) >> 30);
    endfunction

    function automatic void angle_trig(logic [plint_pkg::ANGLE_BITS-1:0] theta,
                                       output longint s, output longint c);
        longint unsigned t;
        t = longint'(theta) << (32 - plint_pkg::ANGLE_BITS);
        s = quarter_sine(t <= 64'h8000_0000 ? t : 64'h1_0000_0000 - t);
        if (t < 64'h8000_0000)
            c = quarter_sine(64'h8000_0000 - t);
        else
            c = -quarter_sine(t - 64'h8000_0000);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic plint_pkg::t_out_word predict_crossing(plint_pkg::t_in_word w);
        plint_pkg::t_out_word o;
        longint    s1, c1, s2, c2, d, x, y, r1, r2;
        angle_trig(w.theta_first, s1, c1);
        angle_trig(w.theta_second, s2, c2);
        r1 = longint'(w.rho_first);
        r2 = longint'(w.rho_second);
        d  = (s1 * c2 - c1 * s2) / (longint'(1) << 30);
        o  = '0;
        if (d == 0) begin
            o.is_parallel = 1'b1;
        end else begin
            x = clamp_coord((r2 * s1 - r1 * s2) / (16 * d));
            y = clamp_coord((r1 * c2 - r2 * c1) / (16 * d));
            o.cross_x = x[15:0];
            o.cross_y = y[15:0];
            o.inside_image = x >= 0 && x < longint'(img_w) &&
                             y >= 0 && y < longint'(img_h);
        end
        return o;
    endfunction

    task automatic report(string msg);
        n_errors++;
        $display("mismatch: %s", msg);
    endtask

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one pair; inputs move on the falling edge
    task automatic send_pair(plint_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (!o_in_ready);
        crossing_q = {crossing_q, predict_crossing(w)};
        n_pairs++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (crossing_q.size() != 0)
            @(negedge i_clk);
        repeat (plint_pkg::PIPE_LAT + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [plint_pkg::DIM_BITS-1:0] value);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == plint_pkg::CFG_WIDTH)
            img_w = value;
        else
            img_h = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_image(logic [plint_pkg::DIM_BITS-1:0] w,
                             logic [plint_pkg::DIM_BITS-1:0] h);
        write_reg(plint_pkg::CFG_WIDTH, w);
        write_reg(plint_pkg::CFG_HEIGHT, h);
    endtask

    function automatic plint_pkg::t_in_word make_pair(int r1, int t1, int r2, int t2);
        plint_pkg::t_in_word w;
        w.rho_first    = r1[15:0];
        w.theta_first  = t1[15:0];
        w.rho_second   = r2[15:0];
        w.theta_second = t2[15:0];
        return w;
    endfunction

    // Line pair likely to cross inside a modest image
    function automatic plint_pkg::t_in_word near_pair();
        return make_pair($urandom_range(0, 16 * 700), $urandom_range(0, 65535),
                         $urandom_range(0, 16 * 700), $urandom_range(0, 65535));
    endfunction

    // Extremes of the fields, axis lines, parallel and far crossings
    task automatic test_directed();
        send_pair(make_pair(16 * 100, 0, 16 * 50, 32768));
        send_pair(make_pair(16 * 639, 0, 16 * 479, 32768));
        send_pair(make_pair(16 * 640, 0, 16 * 10, 32768));
        send_pair(make_pair(-16, 0, 16, 32768));
        send_pair(make_pair(100, 1234, 200, 1234));
        send_pair(make_pair(0, 0, 0, 32768));
        send_pair(make_pair(32767, 0, -32768, 1));
        send_pair(make_pair(-32768, 65535, 32767, 0));
        send_pair(make_pair(32767, 32768, 32767, 16384));
        send_pair(make_pair(-32768, 49152, 32767, 16384));
        send_pair(make_pair(1000, 0, 1000, 65535));
        send_pair(make_pair(500, 16384, 800, 49152));
        send_pair(make_pair(16 * 300, 8192, 16 * 200, 57344));
        send_pair(make_pair(0, 32768, 0, 32769));
        send_pair(make_pair(32767, 65535, -32768, 65535));
        send_pair(make_pair(-1, 21845, -1, 43690));
        send_pair(make_pair(16 * 5, 0, 16 * 5, 0));
        send_pair(make_pair(0, 0, 0, 0));
    endtask

    // Degenerate and extreme image sizes with pairs around the corners
    task automatic test_image_sizes();
        set_image(15'd0, 15'd0);
        send_pair(make_pair(0, 0, 0, 32768));
        send_pair(make_pair(16, 0, 16, 32768));
        set_image(15'd1, 15'd1);
        send_pair(make_pair(0, 0, 0, 32768));
        send_pair(make_pair(16, 0, 0, 32768));
        set_image(15'd32767, 15'd32767);
        send_pair(make_pair(32767, 0, 32767, 32768));
        send_pair(make_pair(16 * 2000, 0, 16 * 1500, 32768));
        for (int i = 0; i < 20; i++)
            send_pair(near_pair());
    endtask

    // Random pairs over several image sizes
    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       set_image(plint_pkg::WIDTH_RESET, plint_pkg::HEIGHT_RESET);
                1:       set_image(15'd32767, 15'd1);
                2:       set_image(15'd1, 15'd32767);
                3:       set_image(15'd0, 15'd480);
                default: set_image(15'($urandom_range(1, 32767)),
                                   15'($urandom_range(1, 32767)));
            endcase
            stalls_on = (ph != 2);
            gaps_on   = (ph != 2);
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                if ($urandom_range(0, 1))
                    send_pair(near_pair());
                else
                    send_pair(plint_pkg::t_in_word'({$urandom, $urandom}));
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Receiver holds off long while the sender streams without gaps
    task automatic test_backpressure();
        wait_drained();
        gaps_on  = 1'b0;
        hold_off = 200;
        for (int i = 0; i < 80; i++)
            send_pair(near_pair());
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // Receiver ready: random stalls, with a counted hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_ready = 1'b0;
                hold_off--;
            end else if (stalls_on) begin
                i_out_ready = ($urandom_range(0, 99) < 70) ? 1'b1
                            : ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
                if (!i_out_ready && $urandom_range(0, 19) == 0)
                    hold_off = $urandom_range(10, 40);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        plint_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (crossing_q.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                exp_w = crossing_q.pop_front();
                if (exp_w.is_parallel)
                    n_parallel++;
                if (exp_w.inside_image)
                    n_inside++;
                if (o_out_word.cross_x !== exp_w.cross_x)
                    report($sformatf("cross_x got %0d want %0d",
                                     o_out_word.cross_x, exp_w.cross_x));
                if (o_out_word.cross_y !== exp_w.cross_y)
                    report($sformatf("cross_y got %0d want %0d",
                                     o_out_word.cross_y, exp_w.cross_y));
                if (o_out_word.is_parallel !== exp_w.is_parallel)
                    report($sformatf("is_parallel got %b want %b",
                                     o_out_word.is_parallel, exp_w.is_parallel));
                if (o_out_word.inside_image !== exp_w.inside_image)
                    report($sformatf("inside_image got %b want %b",
                                     o_out_word.inside_image, exp_w.inside_image));
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results pending", crossing_q.size());
                $display("[polar_line_intersection] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = plint_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        img_w       = plint_pkg::WIDTH_RESET;
        img_h       = plint_pkg::HEIGHT_RESET;
        n_errors    = 0;
        n_pairs     = 0;
        n_results   = 0;
        n_parallel  = 0;
        n_inside    = 0;
        hold_off    = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        quiet_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_image_sizes();
        test_backpressure();
        test_random();
        wait_drained();

        $display("%0d line pairs sent, %0d results checked (%0d parallel, %0d inside)",
                 n_pairs, n_results, n_parallel, n_inside);
        $display("image sizes from zero to full range, long receiver hold-off included");
        if (n_errors == 0 && crossing_q.size() == 0)
            $display("[polar_line_intersection] OK");
        else
            $display("[polar_line_intersection] ERROR");
        $finish;
    end
endmodule

/* files.f */
hdl/plint_pkg.sv
hdl/plint_qsin.sv
hdl/plint_div.sv
hdl/polar_line_intersection.sv
dv/tb_top.sv
